>>> hw/rtl/slid_pkg.sv
// Shared types and constants for the sorted list insert/delete block.
// No dependencies; every other file in hw/rtl imports this package.
package slid_pkg;

  localparam int SLID_CAPACITY   = 16;
  localparam int SLID_DATA_W     = 32;
  localparam int SLID_COUNT_W    = 5;

  typedef logic signed [SLID_DATA_W-1:0] data_t;

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_DELETE = 1'b1
  } req_kind_t;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_DELETED   = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // Broadcast to every cell of the chain for one request.
  typedef struct packed {
    logic  load;       // request changes the list this cycle
    logic  is_delete;  // 1: close the gap, 0: open a slot
    data_t value;      // operand of the request
  } cell_cmd_t;

endpackage

>>> hw/rtl/slid_req_if.sv
// Request channel: valid/ready handshake plus request type and value.
// Depends on slid_pkg.
interface slid_req_if import slid_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  req_type;
  data_t value;

  modport source (output valid, output req_type, output value, input ready);
  modport sink   (input valid, input req_type, input value, output ready);
endinterface

>>> hw/rtl/slid_rsp_if.sv
// Response channel: valid/ready handshake plus status, count and head value.
// Depends on slid_pkg.
interface slid_rsp_if import slid_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [1:0]              status;
  logic [SLID_COUNT_W-1:0] entry_count;
  data_t                   smallest_value;

  modport source (output valid, output status, output entry_count,
                  output smallest_value, input ready);
  modport sink   (input valid, input status, input entry_count,
                  input smallest_value, output ready);
endinterface

>>> hw/rtl/slid_cell.sv
// One compare-and-shift cell of the sorted chain: holds one entry.
// Depends on slid_pkg.
module slid_cell import slid_pkg::*; (
  input  logic      clk,
  input  cell_cmd_t cmd,
  input  logic      found,       // some occupied cell matches the value
  input  logic      occupied,    // this slot is below the fill count
  input  logic      left_ge,     // left neighbor's ge (0 for the head cell)
  input  data_t     left_entry,
  input  data_t     right_entry,
  output logic      ge,          // empty, or entry >= value
  output logic      eq,          // occupied and entry == value
  output data_t     entry,
  output data_t     entry_next
);

  assign ge = !occupied || (entry >= cmd.value);
  assign eq = occupied && (entry == cmd.value);

  always_comb begin
    entry_next = entry;
    if (cmd.load) begin
      if (cmd.is_delete) begin
        // cells at and behind the first match pull from the right
        if (found && ge) begin
          entry_next = right_entry;
        end
      end else if (ge) begin
        // first ge cell takes the value, the rest shift right by one
        entry_next = left_ge ? left_entry : cmd.value;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

>>> hw/rtl/sorted_list_insert_delete.sv
// Top level of the sorted list: a chain of compare-and-shift cells, the
// fill count and a registered response stage. Depends on slid_pkg,
// slid_req_if, slid_rsp_if and slid_cell.
//
//  channel | dir | handshake   | payload
//  --------+-----+-------------+-----------------------------------------
//  req     | in  | valid/ready | req_type (0 insert, 1 delete), value
//  rsp     | out | valid/ready | status, entry_count, smallest_value
//
// All cells compare the value in parallel and shift by one place in the
// same edge, so one request per clock is taken while req.ready is high.
// The response appears in the cycle after acceptance. req.ready is low
// only while a response sits unclaimed in the output register and
// rsp.ready is low. Synchronous reset empties the list (count zero); the
// cell contents are left as they are and never read.
module sorted_list_insert_delete import slid_pkg::*; #(
  parameter int CAPACITY = SLID_CAPACITY
) (
  input logic       clk,
  input logic       rst,
  slid_req_if.sink  req,
  slid_rsp_if.source rsp
);

  localparam int CW = $clog2(CAPACITY + 1);

  // Fill count
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;

  // Per-cell chain signals
  logic [CAPACITY-1:0] occ;
  logic [CAPACITY-1:0] ge;
  logic [CAPACITY-1:0] eq;
  data_t               entry      [CAPACITY];
  data_t               entry_next [CAPACITY];

  logic       accept;
  logic       is_del;
  logic       full;
  logic       found;
  cell_cmd_t  cmd;
  status_t    status_next;
  logic [CW+SLID_COUNT_W-1:0] count_wide;

  assign accept = req.valid && req.ready;
  assign is_del = (req.req_type == REQ_DELETE);
  assign full   = (count == CW'(CAPACITY));
  assign found  = |eq;

  // Output register frees as soon as its content is taken.
  assign req.ready = !rsp.valid || rsp.ready;

  assign cmd.value     = req.value;
  assign cmd.is_delete = is_del;
  assign cmd.load      = accept && (is_del ? found : !full);

  // Cell chain: each cell sees its neighbors' entries and the left ge flag.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic  lge;
    data_t lent;
    data_t rent;

    assign occ[i] = (count > CW'(i));

    if (i == 0) begin : g_head
      assign lge  = 1'b0;
      assign lent = '0;
    end else begin : g_mid
      assign lge  = ge[i-1];
      assign lent = entry[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign rent = '0;   // beyond the count after a delete; never read
    end else begin : g_body
      assign rent = entry[i+1];
    end

    slid_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .found      (found),
      .occupied   (occ[i]),
      .left_ge    (lge),
      .left_entry (lent),
      .right_entry(rent),
      .ge         (ge[i]),
      .eq         (eq[i]),
      .entry      (entry[i]),
      .entry_next (entry_next[i])
    );
  end

  // Count update and status for the request in flight.
  always_comb begin
    count_next  = count;
    status_next = ST_NOT_FOUND;
    if (is_del) begin
      if (found) begin
        count_next  = count - CW'(1);
        status_next = ST_DELETED;
      end
    end else if (full) begin
      status_next = ST_FULL;
    end else begin
      count_next  = count + CW'(1);
      status_next = ST_INSERTED;
    end
  end

  // Response carries the low five bits of the new count.
  assign count_wide = (CW + SLID_COUNT_W)'(count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  // Response payload; head value is zero for an empty list.
  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.status         <= status_next;
      rsp.entry_count    <= count_wide[SLID_COUNT_W-1:0];
      rsp.smallest_value <= (count_next == '0) ? data_t'(0) : entry_next[0];
    end
  end

endmodule

>>> tb/slid_list_checker.sv
// Checker for the sorted list: watches the request and response channels,
// predicts each response and compares it field by field.
// Depends on slid_pkg, slid_req_if and slid_rsp_if.
module slid_list_checker import slid_pkg::*; #(
  parameter int CAPACITY = SLID_CAPACITY
) (
  input  logic clk,
  input  logic rst,
  slid_req_if  req,
  slid_rsp_if  rsp,
  output int   fail_count,
  output int   pending
);

  typedef struct {
    status_t                 status;
    logic [SLID_COUNT_W-1:0] count;
    data_t                   head;
  } list_answer_t;

  // Shadow copy of the list, ascending, first held_len words valid.
  data_t        held_vals [CAPACITY];
  int           held_len;
  list_answer_t answers_due [$];

  initial begin
    fail_count = 0;
    pending    = 0;
    held_len   = 0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: %s: got %0h, want %0h", $time, what, got, want);
    fail_count++;
  endtask

  function automatic list_answer_t apply_request(input req_kind_t kind, input data_t val);
    list_answer_t ans;
    int           pos;
    int           i;
    pos = 0;
    if (kind == REQ_INSERT) begin
      if (held_len >= CAPACITY) begin
        ans.status = ST_FULL;
      end else begin
        // new value goes in front of the first entry not smaller than it
        while (pos < held_len && held_vals[pos] < val) pos++;
        for (i = held_len; i > pos; i--) held_vals[i] = held_vals[i-1];
        held_vals[pos] = val;
        held_len++;
        ans.status = ST_INSERTED;
      end
    end else begin
      while (pos < held_len && held_vals[pos] != val) pos++;
      if (pos < held_len) begin
        for (i = pos; i + 1 < held_len; i++) held_vals[i] = held_vals[i+1];
        held_len--;
        ans.status = ST_DELETED;
      end else begin
        ans.status = ST_NOT_FOUND;
      end
    end
    ans.count = held_len[SLID_COUNT_W-1:0];
    ans.head  = (held_len > 0) ? held_vals[0] : '0;
    return ans;
  endfunction

  // Responses are checked before the request of the same edge is predicted:
  // a response can never leave in the cycle its request is taken.
  always @(posedge clk) begin
    list_answer_t want;
    if (rst) begin
      held_len = 0;
      answers_due.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (answers_due.size() == 0) begin
          report_mismatch("response with no request outstanding", 32'(rsp.status), '0);
        end else begin
          want = answers_due.pop_front();
          if (rsp.status !== want.status)
            report_mismatch("status", 32'(rsp.status), 32'(want.status));
          if (rsp.entry_count !== want.count)
            report_mismatch("entry_count", 32'(rsp.entry_count), 32'(want.count));
          if (rsp.smallest_value !== want.head)
            report_mismatch("smallest_value", rsp.smallest_value, want.head);
        end
      end
      if (req.valid && req.ready)
        answers_due.push_back(apply_request(req_kind_t'(req.req_type), req.value));
    end
    pending = answers_due.size();
  end

endmodule

>>> tb/sorted_list_insert_delete_tb.sv
// Testbench top for the sorted list: clock, reset, request stimulus,
// response back-pressure and the verdict. Depends on slid_pkg, the two
// channel interfaces, sorted_list_insert_delete and slid_list_checker.
module sorted_list_insert_delete_tb;
  import slid_pkg::*;

  localparam int RANDOM_ITEMS = 430;
  localparam int CALM_ITEMS   = 60;     // tail of the run with no idling
  localparam int HOLD_AFTER   = 150;    // requests sent before the long stall
  localparam int HOLD_CYCLES  = 40;
  localparam int CYCLE_LIMIT  = 60000;

  localparam data_t V_MIN = data_t'(32'h8000_0000);
  localparam data_t V_MAX = data_t'(32'h7FFF_FFFF);

  logic clk;
  logic rst;
  int   fail_count;
  int   pending;
  int   sent_count;
  int   cycles;
  bit   calm;
  bit   hold_done;

  // Values that were inserted lately, so that most deletes hit.
  data_t recent_vals [$];

  slid_req_if req_ch ();
  slid_rsp_if rsp_ch ();

  sorted_list_insert_delete #(.CAPACITY(SLID_CAPACITY)) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  slid_list_checker #(.CAPACITY(SLID_CAPACITY)) u_list_check (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Every input known from time zero; the first edge is at time 1.
  initial begin
    clk             = 1'b0;
    rst             = 1'b1;
    req_ch.valid    = 1'b0;
    req_ch.req_type = 1'b0;
    req_ch.value    = '0;
    rsp_ch.ready    = 1'b0;
    sent_count      = 0;
    cycles          = 0;
    calm            = 1'b0;
    hold_done       = 1'b0;
  end

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog: a stuck handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[sorted_list_insert_delete] ERROR");
      $finish;
    end
  end

  // One request: maybe an idle burst first, then hold valid until taken.
  // valid is only lowered at the edge of an idle burst, never lowered and
  // raised in the same step.
  task automatic send_request(input req_kind_t kind, input data_t val);
    int gap;
    if (!calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 3);
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.value    <= val;
    do @(posedge clk); while (!req_ch.ready);
    sent_count++;
  endtask

  // Directed part: empty list, extremes, duplicates, absent values,
  // filling to capacity and an insert into the full list.
  task automatic run_directed();
    int i;
    send_request(REQ_DELETE, data_t'(5));         // delete from empty list
    send_request(REQ_INSERT, V_MAX);
    send_request(REQ_INSERT, V_MIN);
    send_request(REQ_INSERT, V_MIN);              // duplicate goes in front
    send_request(REQ_INSERT, data_t'(0));
    send_request(REQ_INSERT, data_t'(-1));
    send_request(REQ_DELETE, data_t'(7));         // absent value
    send_request(REQ_DELETE, V_MIN);              // removes one copy only
    send_request(REQ_DELETE, V_MAX);              // last entry
    // three held now; fill the rest with mixed-sign values
    for (i = 0; i < SLID_CAPACITY - 3; i++)
      send_request(REQ_INSERT, data_t'((i * 32'h1357_9BDF) ^ 32'hA5A5_0000));
    send_request(REQ_INSERT, data_t'(3));         // full list, rejected
    send_request(REQ_DELETE, data_t'(-1));
    send_request(REQ_INSERT, V_MAX);              // refill the freed slot at the tail
  endtask

  function automatic data_t pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3)
      return data_t'(int'($urandom_range(0, 8)) - 4);   // dense, many duplicates
    if (r == 3) begin
      case ($urandom_range(0, 3))
        0:       return V_MIN;
        1:       return V_MAX;
        2:       return data_t'(0);
        default: return data_t'(-1);
      endcase
    end
    return data_t'($urandom);
  endfunction

  // Random part: phases of 40 requests alternate between mostly inserts and
  // mostly deletes, so the list runs into both the full and the empty case.
  task automatic run_random();
    int    n;
    int    idx;
    int    insert_pct;
    data_t val;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      calm       = (n >= RANDOM_ITEMS - CALM_ITEMS);
      insert_pct = ((n / 40) % 2 == 0) ? 75 : 25;
      if ($urandom_range(0, 99) < insert_pct) begin
        val = pick_value();
        if (recent_vals.size() < 64)
          recent_vals.push_back(val);
        else
          recent_vals[$urandom_range(0, 63)] = val;
        send_request(REQ_INSERT, val);
      end else begin
        if ($urandom_range(0, 9) < 6 && recent_vals.size() > 0) begin
          idx = $urandom_range(0, recent_vals.size() - 1);
          val = recent_vals[idx];
          recent_vals.delete(idx);
        end else begin
          val = pick_value();
        end
        send_request(REQ_DELETE, val);
      end
    end
  endtask

  // Response side: short random stalls, plus one long stall while the
  // sender keeps offering, which fills the output register and must drop
  // req.ready. No stalls in the calm tail.
  initial begin : response_side
    int gap;
    while (rst) @(posedge clk);
    forever begin
      if (!calm && !hold_done && sent_count >= HOLD_AFTER) begin
        hold_done = 1'b1;
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 3);
        rsp_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
        rsp_ch.ready <= 1'b1;
        @(posedge clk);
      end else begin
        rsp_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin : request_side
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    run_random();
    req_ch.valid <= 1'b0;
    // the last request was taken at the previous edge; let the checker see it
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("[sorted_list_insert_delete] OK");
    end else begin
      $display("[sorted_list_insert_delete] ERROR");
    end
    $finish;
  end

endmodule
